@@ rtl/nfcs_pkg.sv @@
// Shared types, command constants and helper functions of the NOR flash command sequencer.
package nfcs_pkg;

  // Default shift of the unlock addresses for the interleaved 32-bit bus.
  localparam int unsigned DEFAULT_ADDRESS_SHIFT = 2;

  // Reset value of the poll limit register.
  localparam logic [7:0] POLL_LIMIT_RESET = 8'd100;

  // Request modes of an input transfer.
  localparam logic [1:0] MODE_PROGRAM = 2'd0;
  localparam logic [1:0] MODE_ERASE   = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  // Kinds of an output transfer.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Unlock word offsets before the bus shift is applied.
  localparam logic [31:0] UNLOCK1_OFFSET = 32'h0000_0555;
  localparam logic [31:0] UNLOCK2_OFFSET = 32'h0000_02aa;

  // Command words, replicated for both 16-bit chips.
  localparam logic [31:0] CMD_UNLOCK1    = 32'h00aa_00aa;
  localparam logic [31:0] CMD_UNLOCK2    = 32'h0055_0055;
  localparam logic [31:0] CMD_ERASE_SET  = 32'h0080_0080;
  localparam logic [31:0] CMD_SECTOR_ERS = 32'h0030_0030;
  localparam logic [31:0] CMD_PROGRAM    = 32'h00a0_00a0;
  localparam logic [31:0] CMD_AUTOSELECT = 32'h0090_0090;
  localparam logic [31:0] CMD_RESET      = 32'h00f0_00f0;
  localparam logic [31:0] PROTECT_MASK   = 32'h00ff_00ff;

  // Input transfer payload.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] target_address;
    logic [31:0] item_data;
  } nfcs_in_t;

  // Output transfer payload.
  typedef struct packed {
    logic [1:0]  cycle_kind;
    logic [31:0] bus_address;
    logic [31:0] bus_data;
    logic        passed;
    logic        is_protected;
    logic        last_of_run;
  } nfcs_out_t;

  // Kind of bus cycle run that one input transfer starts.
  typedef enum logic [2:0] {
    RUN_PROGRAM,
    RUN_ERASE,
    RUN_QUERY,
    RUN_READ,
    RUN_FINISH
  } run_kind_t;

  // Descriptor of a run handed from the control to the emitter.
  typedef struct packed {
    run_kind_t   kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        passed;
    logic        is_protected;
    logic        reset_write;
  } nfcs_run_t;

  // Number of output transfers in a run.
  function automatic logic [2:0] run_length(input nfcs_run_t run);
    logic [2:0] len;
    case (run.kind)
      RUN_PROGRAM: len = 3'd5;
      RUN_ERASE:   len = 3'd7;
      RUN_QUERY:   len = 3'd4;
      RUN_READ:    len = 3'd1;
      RUN_FINISH:  len = run.reset_write ? 3'd2 : 3'd1;
      default:     len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/nfcs_control.sv @@
// Request decode and polling state of the NOR flash command sequencer.
module nfcs_control
  import nfcs_pkg::*;
#(
  parameter int unsigned ADDRESS_SHIFT = DEFAULT_ADDRESS_SHIFT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept_i,
  input  nfcs_in_t  item_i,
  input  logic [7:0] poll_limit_i,
  output logic      load_o,
  output nfcs_run_t run_o
);

  // Sequencer phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_QUERY  = 4'b1000
  } phase_t;

  localparam logic [31:0] QUERY_OFFSET = 32'd2 << ADDRESS_SHIFT;

  phase_t      phase_r, phase_nxt;
  logic        op_is_erase_r, op_is_erase_nxt;
  logic [31:0] saved_address_r, saved_address_nxt;
  logic [1:0]  first_toggle_r, first_toggle_nxt;
  logic [7:0]  poll_count_r, poll_count_nxt;
  logic [7:0]  poll_count_inc;
  logic [1:0]  toggle_now;
  logic        has_run;

  // DQ6 of both chip halves.
  assign toggle_now     = {item_i.item_data[22], item_i.item_data[6]};
  assign poll_count_inc = poll_count_r + 8'd1;

  // Next state and run descriptor for an accepted transfer.
  always_comb begin
    phase_nxt         = phase_r;
    op_is_erase_nxt   = op_is_erase_r;
    saved_address_nxt = saved_address_r;
    first_toggle_nxt  = first_toggle_r;
    poll_count_nxt    = poll_count_r;
    has_run           = 1'b0;
    run_o             = '{kind: RUN_READ, addr: saved_address_r, data: '0,
                          passed: 1'b0, is_protected: 1'b0, reset_write: 1'b0};
    if (item_i.mode != MODE_READ) begin
      // A new request starts only when nothing is in flight.
      if (phase_r == PH_IDLE) begin
        has_run           = 1'b1;
        saved_address_nxt = item_i.target_address;
        poll_count_nxt    = '0;
        run_o.addr        = item_i.target_address;
        run_o.data        = item_i.item_data;
        case (item_i.mode)
          MODE_PROGRAM: begin
            run_o.kind      = RUN_PROGRAM;
            op_is_erase_nxt = 1'b0;
            phase_nxt       = PH_FIRST;
          end
          MODE_ERASE: begin
            run_o.kind      = RUN_ERASE;
            op_is_erase_nxt = 1'b1;
            phase_nxt       = PH_FIRST;
          end
          default: begin
            run_o.kind      = RUN_QUERY;
            run_o.addr      = item_i.target_address + QUERY_OFFSET;
            op_is_erase_nxt = 1'b0;
            phase_nxt       = PH_QUERY;
          end
        endcase
      end
    end else begin
      case (phase_r)
        PH_FIRST: begin
          has_run          = 1'b1;
          first_toggle_nxt = toggle_now;
          phase_nxt        = PH_SECOND;
        end
        PH_SECOND: begin
          has_run = 1'b1;
          if (toggle_now == first_toggle_r) begin
            run_o.kind        = RUN_FINISH;
            run_o.passed      = 1'b1;
            run_o.reset_write = op_is_erase_r;
            phase_nxt         = PH_IDLE;
          end else begin
            poll_count_nxt = poll_count_inc;
            if (poll_count_inc >= poll_limit_i) begin
              run_o.kind        = RUN_FINISH;
              run_o.reset_write = op_is_erase_r;
              phase_nxt         = PH_IDLE;
            end else begin
              phase_nxt = PH_FIRST;
            end
          end
        end
        PH_QUERY: begin
          has_run            = 1'b1;
          run_o.kind         = RUN_FINISH;
          run_o.passed       = 1'b1;
          run_o.is_protected = |(item_i.item_data & PROTECT_MASK);
          run_o.reset_write  = 1'b1;
          phase_nxt          = PH_IDLE;
        end
        default: begin
          has_run = 1'b0;
        end
      endcase
    end
  end

  assign load_o = accept_i && has_run;

  // State registers, updated on every accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      op_is_erase_r   <= 1'b0;
      saved_address_r <= '0;
      first_toggle_r  <= '0;
      poll_count_r    <= '0;
    end else if (accept_i) begin
      phase_r         <= phase_nxt;
      op_is_erase_r   <= op_is_erase_nxt;
      saved_address_r <= saved_address_nxt;
      first_toggle_r  <= first_toggle_nxt;
      poll_count_r    <= poll_count_nxt;
    end
  end

endmodule

@@ rtl/nfcs_emitter.sv @@
// Run register and output register that step a run out one bus cycle per transfer.
module nfcs_emitter
  import nfcs_pkg::*;
#(
  parameter int unsigned ADDRESS_SHIFT = DEFAULT_ADDRESS_SHIFT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load_i,
  input  nfcs_run_t run_i,
  output logic      ready_o,
  output logic      out_valid,
  input  logic      out_stall,
  output nfcs_out_t out_data
);

  localparam logic [31:0] UNLOCK1_ADDR = UNLOCK1_OFFSET << ADDRESS_SHIFT;
  localparam logic [31:0] UNLOCK2_ADDR = UNLOCK2_OFFSET << ADDRESS_SHIFT;

  nfcs_run_t  run_r;
  logic       run_active_r;
  logic [2:0] idx_r;
  logic       out_valid_r;
  nfcs_out_t  out_r;
  nfcs_out_t  result;
  logic [2:0] run_len;
  logic       last;
  logic       out_free;
  logic       step;

  function automatic nfcs_out_t bus_cycle(input logic [1:0] kind, input logic [31:0] addr,
                                          input logic [31:0] data);
    nfcs_out_t r;
    r              = '0;
    r.cycle_kind   = kind;
    r.bus_address  = addr;
    r.bus_data     = data;
    return r;
  endfunction

  assign run_len  = run_length(run_r);
  assign last     = (idx_r == run_len - 3'd1);
  assign out_free = !out_valid_r || !out_stall;
  assign step     = run_active_r && out_free;
  assign ready_o  = !run_active_r || (step && last);

  // Bus cycle at the current position of the run.
  always_comb begin
    result = '0;
    case (run_r.kind)
      RUN_PROGRAM: begin
        case (idx_r)
          3'd0:    result = bus_cycle(KIND_WRITE, UNLOCK1_ADDR, CMD_UNLOCK1);
          3'd1:    result = bus_cycle(KIND_WRITE, UNLOCK2_ADDR, CMD_UNLOCK2);
          3'd2:    result = bus_cycle(KIND_WRITE, UNLOCK1_ADDR, CMD_PROGRAM);
          3'd3:    result = bus_cycle(KIND_WRITE, run_r.addr, run_r.data);
          default: result = bus_cycle(KIND_READ, run_r.addr, '0);
        endcase
      end
      RUN_ERASE: begin
        case (idx_r)
          3'd0:    result = bus_cycle(KIND_WRITE, UNLOCK1_ADDR, CMD_UNLOCK1);
          3'd1:    result = bus_cycle(KIND_WRITE, UNLOCK2_ADDR, CMD_UNLOCK2);
          3'd2:    result = bus_cycle(KIND_WRITE, UNLOCK1_ADDR, CMD_ERASE_SET);
          3'd3:    result = bus_cycle(KIND_WRITE, UNLOCK1_ADDR, CMD_UNLOCK1);
          3'd4:    result = bus_cycle(KIND_WRITE, UNLOCK2_ADDR, CMD_UNLOCK2);
          3'd5:    result = bus_cycle(KIND_WRITE, run_r.addr, CMD_SECTOR_ERS);
          default: result = bus_cycle(KIND_READ, run_r.addr, '0);
        endcase
      end
      RUN_QUERY: begin
        case (idx_r)
          3'd0:    result = bus_cycle(KIND_WRITE, UNLOCK1_ADDR, CMD_UNLOCK1);
          3'd1:    result = bus_cycle(KIND_WRITE, UNLOCK2_ADDR, CMD_UNLOCK2);
          3'd2:    result = bus_cycle(KIND_WRITE, UNLOCK1_ADDR, CMD_AUTOSELECT);
          default: result = bus_cycle(KIND_READ, run_r.addr, '0);
        endcase
      end
      RUN_READ: begin
        result = bus_cycle(KIND_READ, run_r.addr, '0);
      end
      RUN_FINISH: begin
        // The reset write, when present, comes before the finish report.
        if (run_r.reset_write && idx_r == 3'd0) begin
          result = bus_cycle(KIND_WRITE, '0, CMD_RESET);
        end else begin
          result              = bus_cycle(KIND_DONE, '0, '0);
          result.passed       = run_r.passed;
          result.is_protected = run_r.is_protected;
        end
      end
      default: begin
        result = '0;
      end
    endcase
    result.last_of_run = last;
  end

  // Run register and position counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      idx_r        <= '0;
    end else if (load_i) begin
      run_active_r <= 1'b1;
      idx_r        <= '0;
    end else if (step && last) begin
      run_active_r <= 1'b0;
    end else if (step) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      run_r <= run_i;
    end
  end

  // Output register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The position never runs past the end of the active run.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_active_r |-> (idx_r < run_len))
    else $error("run position beyond run length");

  // A new run is only loaded when the previous one is finishing or gone.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> ready_o)
    else $error("run loaded while emitter busy");

  // The last step of a run marks its transfer as the final one.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last) |=> (out_valid_r && out_r.last_of_run))
    else $error("final transfer of run not marked");

  // A run that finished without a new load leaves the emitter idle.
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last && !load_i) |=> !run_active_r)
    else $error("run did not end after its last step");

endmodule

@@ rtl/nor_flash_command_sequencer_unit.sv @@
// Top level of the NOR flash command sequencer for two interleaved 16-bit chips.
//
// Input channel (in_valid / in_stall / in_data): requests to program a word,
// erase a sector or query protection, and bus read data returned for the
// block's own read cycles. Output channel (out_valid / out_stall / out_data):
// bus writes, bus read requests and one finish report per operation, with
// last_of_run set on the final transfer caused by each input transfer.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): the poll limit;
// cfg_ready is always high. The limit must be written only while the block is
// idle; the block does not enforce this. A run is loaded into the run register;
// its bus cycles pass through the output register, one per clock unless the
// receiver stalls: 5 for program, 7 for erase, 4 for query; a read return
// emits 1 or 2, or none while idle. The next input transfer is taken in the
// cycle the last bus cycle of the current run moves into the output register,
// so throughput is set by the run length. Reset clears the phase, poll
// counter and both valid flags and sets the poll limit to 100. While the
// receiver stalls, the output register holds and in_stall is high in a run.
module nor_flash_command_sequencer_unit
  import nfcs_pkg::*;
#(
  parameter int unsigned ADDRESS_SHIFT = DEFAULT_ADDRESS_SHIFT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  nfcs_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output nfcs_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] poll_limit_r;
  logic       emit_ready;
  logic       in_accept;
  logic       run_load;
  nfcs_run_t  run_desc;

  assign cfg_ready = 1'b1;
  assign in_stall  = !emit_ready;
  assign in_accept = in_valid && emit_ready;

  // Poll limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      poll_limit_r <= cfg_data;
    end
  end

  nfcs_control #(
    .ADDRESS_SHIFT(ADDRESS_SHIFT)
  ) u_control (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept_i     (in_accept),
    .item_i       (in_data),
    .poll_limit_i (poll_limit_r),
    .load_o       (run_load),
    .run_o        (run_desc)
  );

  nfcs_emitter #(
    .ADDRESS_SHIFT(ADDRESS_SHIFT)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (run_load),
    .run_i     (run_desc),
    .ready_o   (emit_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ test/tb_nor_flash_command_sequencer_unit.sv @@
// Self-checking testbench for the NOR flash command sequencer unit.
`timescale 1ns / 100ps

module tb_nor_flash_command_sequencer_unit;
  import nfcs_pkg::*;

  localparam int unsigned ADDR_SHIFT = DEFAULT_ADDRESS_SHIFT;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 180;

  // Sequencer phases as tracked by the predictor.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_POLL_FIRST,
    PH_POLL_SECOND,
    PH_QUERY_READ
  } flash_phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  nfcs_in_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  nfcs_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  // Predictor state.
  flash_phase_t flash_phase = PH_IDLE;
  logic         op_is_erase_model = 1'b0;
  logic [31:0]  saved_address_model = '0;
  logic [1:0]   first_bits_model = '0;
  logic [7:0]   poll_count_model = '0;
  logic [7:0]   poll_limit_model = POLL_LIMIT_RESET;

  // Bus cycles expected from the block, oldest first.
  nfcs_out_t expected_cycles[$];
  nfcs_out_t new_cycles[$];

  // Traffic shaping knobs.
  int gap_pct = 14;
  int stall_pct = 14;
  int noise_pct = 0;
  int hold_left = 0;

  // Bookkeeping.
  int error_count = 0;
  int checked_cycles = 0;
  int sent_items = 0;
  int useful_items = 0;
  int ops_started = 0;
  int ops_passed = 0;
  int ops_failed = 0;
  int protected_seen = 0;
  int quiet_cycles = 0;

  nor_flash_command_sequencer_unit #(
    .ADDRESS_SHIFT(ADDR_SHIFT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver either holds off for a counted stretch or stalls at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want,
             checked_cycles);
    error_count++;
  endtask

  // Every output transfer is compared with the oldest expected bus cycle.
  always @(posedge clk) begin
    nfcs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_cycles++;
      if (expected_cycles.size() == 0) begin
        report_mismatch("bus cycle with nothing expected, address", out_data.bus_address, '0);
      end else begin
        want = expected_cycles.pop_front();
        if (out_data.cycle_kind !== want.cycle_kind)
          report_mismatch("cycle_kind", 32'(out_data.cycle_kind), 32'(want.cycle_kind));
        if (out_data.bus_address !== want.bus_address)
          report_mismatch("bus_address", out_data.bus_address, want.bus_address);
        if (out_data.bus_data !== want.bus_data)
          report_mismatch("bus_data", out_data.bus_data, want.bus_data);
        if (out_data.passed !== want.passed)
          report_mismatch("passed", 32'(out_data.passed), 32'(want.passed));
        if (out_data.is_protected !== want.is_protected)
          report_mismatch("is_protected", 32'(out_data.is_protected),
                          32'(want.is_protected));
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 32'(out_data.last_of_run),
                          32'(want.last_of_run));
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d bus cycles still expected",
                 QUIET_LIMIT, expected_cycles.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Append one predicted bus cycle to the current run.
  function automatic void emit_cycle(input logic [1:0] kind, input logic [31:0] addr,
                                     input logic [31:0] data, input logic pass,
                                     input logic prot);
    nfcs_out_t c;
    c = '0;
    c.cycle_kind = kind;
    c.bus_address = addr;
    c.bus_data = data;
    c.passed = pass;
    c.is_protected = prot;
    new_cycles.push_back(c);
  endfunction

  // Close an operation: erase and query end with a reset write, then the report.
  function automatic void emit_finish(input logic pass, input logic prot);
    if (op_is_erase_model || prot || flash_phase == PH_QUERY_READ)
      emit_cycle(KIND_WRITE, '0, CMD_RESET, 1'b0, 1'b0);
    emit_cycle(KIND_DONE, '0, '0, pass, prot);
    if (pass) ops_passed++;
    else ops_failed++;
    if (prot) protected_seen++;
    flash_phase = PH_IDLE;
  endfunction

  // Work out the bus cycles that one accepted input transfer causes.
  function automatic int predict_bus_cycles(input nfcs_in_t item);
    logic [31:0] unlock1;
    logic [31:0] unlock2;
    logic [1:0]  bits;
    nfcs_out_t   tail;
    int          n;
    unlock1 = UNLOCK1_OFFSET << ADDR_SHIFT;
    unlock2 = UNLOCK2_OFFSET << ADDR_SHIFT;
    bits = {item.item_data[22], item.item_data[6]};
    new_cycles.delete();
    if (item.mode != MODE_READ) begin
      if (flash_phase == PH_IDLE) begin
        ops_started++;
        emit_cycle(KIND_WRITE, unlock1, CMD_UNLOCK1, 1'b0, 1'b0);
        emit_cycle(KIND_WRITE, unlock2, CMD_UNLOCK2, 1'b0, 1'b0);
        case (item.mode)
          MODE_PROGRAM: begin
            emit_cycle(KIND_WRITE, unlock1, CMD_PROGRAM, 1'b0, 1'b0);
            emit_cycle(KIND_WRITE, item.target_address, item.item_data, 1'b0, 1'b0);
            emit_cycle(KIND_READ, item.target_address, '0, 1'b0, 1'b0);
            op_is_erase_model = 1'b0;
            flash_phase = PH_POLL_FIRST;
          end
          MODE_ERASE: begin
            emit_cycle(KIND_WRITE, unlock1, CMD_ERASE_SET, 1'b0, 1'b0);
            emit_cycle(KIND_WRITE, unlock1, CMD_UNLOCK1, 1'b0, 1'b0);
            emit_cycle(KIND_WRITE, unlock2, CMD_UNLOCK2, 1'b0, 1'b0);
            emit_cycle(KIND_WRITE, item.target_address, CMD_SECTOR_ERS, 1'b0, 1'b0);
            emit_cycle(KIND_READ, item.target_address, '0, 1'b0, 1'b0);
            op_is_erase_model = 1'b1;
            flash_phase = PH_POLL_FIRST;
          end
          default: begin
            emit_cycle(KIND_WRITE, unlock1, CMD_AUTOSELECT, 1'b0, 1'b0);
            emit_cycle(KIND_READ, item.target_address + (32'd2 << ADDR_SHIFT), '0,
                       1'b0, 1'b0);
            op_is_erase_model = 1'b0;
            flash_phase = PH_QUERY_READ;
          end
        endcase
        saved_address_model = item.target_address;
        poll_count_model = '0;
      end
    end else begin
      case (flash_phase)
        PH_POLL_FIRST: begin
          first_bits_model = bits;
          emit_cycle(KIND_READ, saved_address_model, '0, 1'b0, 1'b0);
          flash_phase = PH_POLL_SECOND;
        end
        PH_POLL_SECOND: begin
          if (bits == first_bits_model) begin
            emit_finish(1'b1, 1'b0);
          end else begin
            poll_count_model = poll_count_model + 8'd1;
            if (poll_count_model >= poll_limit_model) begin
              emit_finish(1'b0, 1'b0);
            end else begin
              emit_cycle(KIND_READ, saved_address_model, '0, 1'b0, 1'b0);
              flash_phase = PH_POLL_FIRST;
            end
          end
        end
        PH_QUERY_READ: emit_finish(1'b1, (item.item_data & PROTECT_MASK) != '0);
        default: ;
      endcase
    end
    n = new_cycles.size();
    if (n > 0) begin
      tail = new_cycles.pop_back();
      tail.last_of_run = 1'b1;
      new_cycles.push_back(tail);
    end
    foreach (new_cycles[i]) expected_cycles.push_back(new_cycles[i]);
    return n;
  endfunction

  function automatic nfcs_in_t make_item(input logic [1:0] mode, input logic [31:0] addr,
                                         input logic [31:0] data);
    nfcs_in_t item;
    item.mode = mode;
    item.target_address = addr;
    item.item_data = data;
    return item;
  endfunction

  // Random word with the all-zero and all-one extremes mixed in.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random flash read data carrying the given DQ6 bits of both chips.
  function automatic logic [31:0] read_word(input logic [1:0] bits);
    logic [31:0] w;
    w = $urandom;
    w[6] = bits[0];
    w[22] = bits[1];
    return w;
  endfunction

  // Offer one item at the falling edge and hold it until the transfer.
  task automatic send_item(input nfcs_in_t item);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (predict_bus_cycles(item) > 0) useful_items++;
  endtask

  // Stop offering items and let every expected bus cycle come out.
  task automatic wait_bus_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_cycles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the poll limit; only called once the block is idle.
  task automatic write_poll_limit(input logic [7:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    poll_limit_model = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Answer the block's reads until the operation ends. The first busy_pairs
  // poll pairs differ in DQ6; a query is answered with status_word.
  task automatic complete_op(input int busy_pairs, input logic [31:0] status_word);
    logic [1:0] first;
    int pairs;
    pairs = 0;
    first = '0;
    while (flash_phase != PH_IDLE) begin
      // A request while busy must be ignored.
      if ($urandom_range(99) < noise_pct)
        send_item(make_item(2'($urandom_range(2)), rand_word(), rand_word()));
      case (flash_phase)
        PH_POLL_FIRST: begin
          first = 2'($urandom_range(3));
          send_item(make_item(MODE_READ, rand_word(), read_word(first)));
        end
        PH_POLL_SECOND: begin
          if (pairs < busy_pairs)
            send_item(make_item(MODE_READ, rand_word(),
                                read_word(first ^ 2'($urandom_range(1, 3)))));
          else
            send_item(make_item(MODE_READ, rand_word(), read_word(first)));
          pairs++;
        end
        default: send_item(make_item(MODE_READ, rand_word(), status_word));
      endcase
    end
  endtask

  task automatic do_flash_op(input logic [1:0] mode, input logic [31:0] addr,
                             input logic [31:0] data, input int busy_pairs,
                             input logic [31:0] status_word);
    send_item(make_item(mode, addr, data));
    complete_op(busy_pairs, status_word);
  endtask

  // Program at both address extremes, once at once and once after toggling.
  task automatic test_program_word();
    do_flash_op(MODE_PROGRAM, '0, '0, 0, '0);
    do_flash_op(MODE_PROGRAM, '1, '1, 2, '0);
  endtask

  // Sector erase with and without toggle polling before completion.
  task automatic test_sector_erase();
    do_flash_op(MODE_ERASE, 32'h0001_0000, '0, 1, '0);
    do_flash_op(MODE_ERASE, '1, '1, 0, '0);
  endtask

  // Protection query: unprotected with only high bytes set, address that
  // wraps, and protection seen in either chip's low byte.
  task automatic test_protect_query();
    do_flash_op(MODE_QUERY, 32'hffff_fffc, '0, 0, 32'hff00_ff00);
    do_flash_op(MODE_QUERY, '0, '1, 0, 32'h0000_0001);
    do_flash_op(MODE_QUERY, 32'h1234_5678, '0, 0, 32'h0080_0000);
  endtask

  // Read data while idle and a request while busy cause nothing.
  task automatic test_ignored_items();
    send_item(make_item(MODE_READ, '1, '1));
    send_item(make_item(MODE_PROGRAM, 32'h0000_0400, 32'hdead_beef));
    send_item(make_item(MODE_ERASE, '0, '0));
    complete_op(0, '0);
  endtask

  // Poll timeouts at limits of one, zero (acts as one) and two.
  task automatic test_poll_limit();
    wait_bus_idle();
    write_poll_limit(8'd1);
    do_flash_op(MODE_ERASE, 32'h0002_0000, '0, 1, '0);
    wait_bus_idle();
    write_poll_limit(8'd0);
    do_flash_op(MODE_PROGRAM, 32'h0000_0010, 32'h5a5a_a5a5, 5, '0);
    wait_bus_idle();
    write_poll_limit(8'd2);
    do_flash_op(MODE_PROGRAM, 32'h0000_0020, 32'h0f0f_f0f0, 2, '0);
  endtask

  // The receiver holds off while items keep coming, so the block fills up
  // and stalls its input; afterwards the sender waits for everything.
  task automatic test_backpressure();
    wait_bus_idle();
    write_poll_limit(8'd10);
    gap_pct = 0;
    hold_left = 80;
    do_flash_op(MODE_ERASE, rand_word(), rand_word(), 3, '0);
    do_flash_op(MODE_PROGRAM, rand_word(), rand_word(), 1, '0);
    wait_bus_idle();
    gap_pct = 14;
  endtask

  // Random operations over several poll limits, with noise and pauses.
  task automatic test_random_traffic();
    logic [7:0] limits[4];
    int items_per_phase[4];
    int goal;
    int busy;
    logic [31:0] status;
    limits = '{8'd255, 8'($urandom_range(1, 6)), 8'd3, POLL_LIMIT_RESET};
    items_per_phase = '{45, 45, 45, RANDOM_ITEMS - 135};
    for (int p = 0; p < 4; p++) begin
      wait_bus_idle();
      write_poll_limit(limits[p]);
      // The third phase runs with no sender gaps and no receiver stalls.
      gap_pct = (p == 2) ? 0 : 14;
      stall_pct = (p == 2) ? 0 : 14;
      noise_pct = 8;
      goal = useful_items + items_per_phase[p];
      while (useful_items < goal) begin
        if ($urandom_range(99) < 8)
          send_item(make_item(MODE_READ, rand_word(), rand_word()));
        if (limits[p] <= 8'd6 && $urandom_range(99) < 30)
          busy = int'(limits[p]);
        else
          busy = $urandom_range(3);
        status = rand_word();
        if ($urandom_range(99) < 30) status = status & ~PROTECT_MASK;
        do_flash_op(2'($urandom_range(2)), rand_word(), rand_word(), busy, status);
        if ($urandom_range(99) < 10) wait_bus_idle();
      end
    end
    noise_pct = 0;
    gap_pct = 14;
    stall_pct = 14;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_program_word();
    test_sector_erase();
    test_protect_query();
    test_ignored_items();
    test_poll_limit();
    test_backpressure();
    test_random_traffic();
    wait_bus_idle();
    $display("Run covered %0d input transfers and %0d checked bus cycles.",
             sent_items, checked_cycles);
    $display("Operations: %0d started, %0d completed, %0d timed out, %0d protected.",
             ops_started, ops_passed, ops_failed, protected_seen);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/nfcs_pkg.sv
rtl/nfcs_control.sv
rtl/nfcs_emitter.sv
rtl/nor_flash_command_sequencer_unit.sv
test/tb_nor_flash_command_sequencer_unit.sv
